### rtl/sync_length_checksum_framer_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the framer checker
// Each macro expects clk in scope; the implication macros also expect arst_n.
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_CHECKSUM_FRAMER_CORE_MACROS_SVH
`define SYNC_LENGTH_CHECKSUM_FRAMER_CORE_MACROS_SVH

// Same-cycle implication, masked while in reset
`define SLCF_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, masked while in reset
`define SLCF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Checked at every edge, reset included
`define SLCF_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) (expr)) else $error(msg);

`endif

### rtl/slcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcf_pkg
// Types, constants and helpers for the sync/length/checksum framer.
// ----------------------------------------------------------------------------
package slcf_pkg;

	// Field widths
	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 9;
	localparam int SUM_W      = 16;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_PAD_W   = 2;

	// Configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic CFG_IDX_MAX_FRAME_LEN = 1'b0;

	// Header and length constants
	localparam logic [BYTE_W-1:0] START_BYTE   = 8'h01;
	localparam logic [BYTE_W-1:0] SYNC_COMP    = 8'hFF;
	localparam logic [LEN_W-1:0]  LEN_EXTRA    = 9'd6;
	localparam logic [LEN_W-1:0]  MAX_LEN_RST  = 9'd261;
	localparam logic [LEN_W-1:0]  POS_HDR_LAST = 9'd2;
	localparam logic [LEN_W-1:0]  POS_LEN      = 9'd3;

	// Known message ids
	localparam logic [BYTE_W-1:0] ID_KNOWN_A = 8'd20;
	localparam logic [BYTE_W-1:0] ID_KNOWN_B = 8'd21;
	localparam logic [BYTE_W-1:0] ID_KNOWN_C = 8'd22;
	localparam logic [BYTE_W-1:0] ID_KNOWN_D = 8'd23;
	localparam logic [BYTE_W-1:0] ID_KNOWN_E = 8'd67;

	typedef enum logic [2:0] {
		ST_HUNT     = 3'd0,
		ST_IN_FRAME = 3'd1,
		ST_GOOD     = 3'd2,
		ST_CSUM_ERR = 3'd3,
		ST_LEN_ERR  = 3'd4
	} status_t;

	// One result item
	typedef struct packed {
		logic              known_id;
		logic [LEN_W-1:0]  frame_length;
		logic [BYTE_W-1:0] message_id;
		logic [LEN_W-1:0]  position;
		logic [BYTE_W-1:0] byte_out;
		status_t           status;
	} result_t;

	function automatic logic is_known_id(input logic [BYTE_W-1:0] id);
		return (id == ID_KNOWN_A) || (id == ID_KNOWN_B) || (id == ID_KNOWN_C) ||
			(id == ID_KNOWN_D) || (id == ID_KNOWN_E);
	endfunction

endpackage

### rtl/sync_length_checksum_framer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_checksum_framer_core
// Byte-serial frame synchroniser with length limit and 16-bit sum checksum.
// ----------------------------------------------------------------------------
// Takes one receiver byte per transaction and returns exactly one result per
// byte, in order. Sustained rate is one byte per clock while the output is not
// stalled; a byte is held in the input register, loaded at the accepting edge,
// and its result in the result register, as the whole frame state update is
// combinational from the input register to the result register.
// Backpressure on the output stalls the input side with no loss.
// max_frame_len should be written only while no byte is in flight. No
// start-up sweep: the block is ready out of reset.
// ----------------------------------------------------------------------------
module sync_length_checksum_framer_core
	import slcf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] byte_in
	// result stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [2:0] status, [10:3] byte_out, [19:11] position, [27:20] message_id,
	// [36:28] frame_length, [37] known_id, [39:38] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// configuration
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [CFG_ADDR_W-1:0]  paddr,
	input  logic [CFG_DATA_W-1:0]  pwdata,
	output logic [CFG_DATA_W-1:0]  prdata,
	output logic                   pready
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              valid_s2;
	result_t           res_s2;
	result_t           res;
	logic              advance;
	logic [LEN_W-1:0]  max_frame_len;

	slcf_cfg_regs u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.max_frame_len (max_frame_len)
	);

	// Stage 1 byte moves on when the result register is free or draining
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata[BYTE_W-1:0];
		end
	end

	slcf_engine u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.byte_s1       (byte_s1),
		.max_frame_len (max_frame_len),
		.res           (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, res_s2};

endmodule

### rtl/slcf_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcf_cfg_regs
// APB register file holding the maximum frame length.
// ----------------------------------------------------------------------------
module slcf_cfg_regs
	import slcf_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [LEN_W-1:0]      max_frame_len
);

	logic [LEN_W-1:0] max_frame_len_q;
	logic             wr_en;
	logic             idx;

	assign pready = 1'b1;
	assign idx    = paddr[CFG_ADDR_W-1];
	assign wr_en  = psel & penable & pwrite & pready;

	// Register write in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_len_q <= MAX_LEN_RST;
		end else if (wr_en && (idx == CFG_IDX_MAX_FRAME_LEN)) begin
			max_frame_len_q <= pwdata[LEN_W-1:0];
		end
	end

	// Read-back
	always_comb begin
		prdata = '0;
		if (idx == CFG_IDX_MAX_FRAME_LEN) begin
			prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, max_frame_len_q};
		end
	end

	assign max_frame_len = max_frame_len_q;

endmodule

### rtl/slcf_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcf_engine
// Frame state and per-byte decision: header hunt, length check, running sum
// and checksum compare. Result is combinational from the staged byte.
// ----------------------------------------------------------------------------
module slcf_engine
	import slcf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [BYTE_W-1:0] byte_s1,
	input  logic [LEN_W-1:0]  max_frame_len,
	output result_t           res
);

	logic [BYTE_W-1:0] win0_q, win1_q, win0_d, win1_d;
	logic [LEN_W-1:0]  byte_count_q, byte_count_d;
	logic [LEN_W-1:0]  exp_len_q, exp_len_d;
	logic [SUM_W-1:0]  sum_q, sum_d;
	logic [BYTE_W-1:0] csum_low_q, csum_low_d;
	logic [BYTE_W-1:0] cur_id_q, cur_id_d;

	logic             hunting;
	logic             hdr_hit;
	logic [LEN_W-1:0] pos_inc;
	logic [LEN_W-1:0] len_val;
	logic [LEN_W:0]   pos_plus2;
	logic [SUM_W-1:0] sum_add;
	logic             csum_ok;

	assign hunting   = (byte_count_q == '0);
	assign hdr_hit   = (win0_q == START_BYTE) && ((win1_q ^ byte_s1) == SYNC_COMP);
	assign pos_inc   = byte_count_q + 9'd1;
	assign len_val   = {1'b0, byte_s1} + LEN_EXTRA;
	assign pos_plus2 = {1'b0, byte_count_q} + 10'd2;
	assign sum_add   = sum_q + {{(SUM_W-BYTE_W){1'b0}}, byte_s1};
	assign csum_ok   = (sum_q[SUM_W-1:BYTE_W] == byte_s1) && (sum_q[BYTE_W-1:0] == csum_low_q);

	// Next state and result
	always_comb begin
		win0_d       = win0_q;
		win1_d       = win1_q;
		byte_count_d = byte_count_q;
		exp_len_d    = exp_len_q;
		sum_d        = sum_q;
		csum_low_d   = csum_low_q;
		cur_id_d     = cur_id_q;

		res.status       = ST_HUNT;
		res.byte_out     = byte_s1;
		res.position     = '0;
		res.frame_length = '0;

		priority if (hunting) begin
			win0_d = win1_q;
			win1_d = byte_s1;
			if (hdr_hit) begin
				byte_count_d = POS_LEN;
				cur_id_d     = win1_q;
				exp_len_d    = '0;
				sum_d        = {{(SUM_W-BYTE_W){1'b0}}, START_BYTE}
					+ {{(SUM_W-BYTE_W){1'b0}}, win1_q}
					+ {{(SUM_W-BYTE_W){1'b0}}, byte_s1};
				res.status   = ST_IN_FRAME;
				res.position = POS_HDR_LAST;
			end
		end else if (byte_count_q == POS_LEN) begin
			// length byte
			exp_len_d        = len_val;
			res.position     = byte_count_q;
			res.frame_length = len_val;
			if (len_val > max_frame_len) begin
				byte_count_d = '0;
				res.status   = ST_LEN_ERR;
			end else begin
				byte_count_d = pos_inc;
				sum_d        = sum_add;
				res.status   = ST_IN_FRAME;
			end
		end else if (pos_inc < exp_len_q) begin
			// body or checksum low byte
			byte_count_d     = pos_inc;
			res.status       = ST_IN_FRAME;
			res.position     = byte_count_q;
			res.frame_length = exp_len_q;
			if (pos_plus2 < {1'b0, exp_len_q}) begin
				sum_d = sum_add;
			end else begin
				csum_low_d = byte_s1;
			end
		end else begin
			// last byte: checksum high
			byte_count_d     = '0;
			res.status       = csum_ok ? ST_GOOD : ST_CSUM_ERR;
			res.position     = byte_count_q;
			res.frame_length = exp_len_q;
		end

		res.message_id = cur_id_d;
		res.known_id   = is_known_id(cur_id_d);
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win0_q       <= '0;
			win1_q       <= '0;
			byte_count_q <= '0;
			exp_len_q    <= '0;
			sum_q        <= '0;
			csum_low_q   <= '0;
			cur_id_q     <= '0;
		end else if (step) begin
			win0_q       <= win0_d;
			win1_q       <= win1_d;
			byte_count_q <= byte_count_d;
			exp_len_q    <= exp_len_d;
			sum_q        <= sum_d;
			csum_low_q   <= csum_low_d;
			cur_id_q     <= cur_id_d;
		end
	end

endmodule

### rtl/slcf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcf_checker
// Port-level checks on the framer's result stream.
// ----------------------------------------------------------------------------
`include "sync_length_checksum_framer_core_macros.svh"

module slcf_checker
	import slcf_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	result_t          r;
	logic [LEN_W-1:0] pos_next;
	logic             frame_end;

	assign r         = m_tdata[OUT_TDATA_W-OUT_PAD_W-1:0];
	assign pos_next  = r.position + 9'd1;
	assign frame_end = (r.status == ST_GOOD) || (r.status == ST_CSUM_ERR);

	// A stalled result holds
	`SLCF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// Nothing offered during reset
	`SLCF_ASSERT_ALWAYS(a_rst_quiet, arst_n || !m_tvalid, "result offered in reset")

	// From the length byte on, a frame byte always lies inside the frame length
	`SLCF_ASSERT_IMPL(a_in_frame_len, m_tvalid && (r.status == ST_IN_FRAME) && (r.position >= POS_LEN), r.frame_length > r.position, "frame byte beyond frame length")

	// The checksum verdict comes on the last byte of the frame
	`SLCF_ASSERT_IMPL(a_end_pos, m_tvalid && frame_end, pos_next == r.frame_length, "frame end at wrong position")

endmodule

bind sync_length_checksum_framer_core slcf_checker u_slcf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
